// ===== hdl/rsbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rsbst_pkg
// shared constants for the segment versus box slab test
// ----------------------------------------------------------------------------
package rsbst_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned T_FRAC_BITS_DEF = 16;

endpackage

// ===== hdl/ray_segment_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_segment_box_slab_test
// pipelined slab test of a line segment against an axis-aligned box
// ----------------------------------------------------------------------------
// Takes one segment/box word per cycle while not stalled and returns one
// result word per test, in order. Five stages form the slab crossings as
// exact fractions and reduce them to an interval, then a restoring divider
// settles one bit of the entry parameter per stage. The whole pipeline
// advances together whenever the output register is empty or being taken,
// so in_tready follows out_tready and a stall loses nothing.
// On a miss entry_param reads as zero.
module ray_segment_box_slab_test #(
  parameter int unsigned COORD_WIDTH = rsbst_pkg::COORD_WIDTH_DEF,
  parameter int unsigned T_FRAC_BITS = rsbst_pkg::T_FRAC_BITS_DEF,
  localparam int unsigned IN_BITS  = 9 * COORD_WIDTH + 3 * (COORD_WIDTH - 1),
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = T_FRAC_BITS + 2,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, box_center_x,
  // box_center_y, box_center_z, box_size_x, box_size_y, box_size_z
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // hit, entry_param
  output logic [OUT_W-1:0] out_tdata
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned F   = T_FRAC_BITS;
  localparam int unsigned NW  = W + 3;   // signed slab numerators
  localparam int unsigned FW  = W + 2;   // clamped fraction parts
  localparam int unsigned DS  = F + 1;   // divider stages

  function automatic logic frac_gt(input logic [FW-1:0] an, input logic [FW-1:0] ad,
                                   input logic [FW-1:0] bn, input logic [FW-1:0] bd);
    logic [2*FW-1:0] p1;
    logic [2*FW-1:0] p2;
    p1 = (2*FW)'(an) * (2*FW)'(bd);
    p2 = (2*FW)'(bn) * (2*FW)'(ad);
    return p1 > p2;
  endfunction

  logic ce;
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  // stage 1: slab bounds relative to the start point
  logic                 s1_v_r;
  logic signed [NW-1:0] s1_nlo_r [3];
  logic signed [NW-1:0] s1_nhi_r [3];
  logic [FW-1:0]        s1_den_r [3];
  logic [2:0]           s1_dz_r;
  logic [2:0]           s1_zmiss_r;

  logic signed [NW-1:0] s1_nlo_nxt [3];
  logic signed [NW-1:0] s1_nhi_nxt [3];
  logic [FW-1:0]        s1_den_nxt [3];
  logic [2:0]           s1_dz_nxt;
  logic [2:0]           s1_zmiss_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [W-1:0]  o;
      logic signed [W-1:0]  e;
      logic signed [W-1:0]  c;
      logic [W-2:0]         s;
      logic signed [W:0]    d;
      logic [W:0]           absd;
      logic signed [NW-1:0] o2;
      logic signed [NW-1:0] lo2;
      logic signed [NW-1:0] hi2;
      logic signed [NW-1:0] nlo;
      logic signed [NW-1:0] nhi;
      o    = $signed(in_tdata[a*W +: W]);
      e    = $signed(in_tdata[(3+a)*W +: W]);
      c    = $signed(in_tdata[(6+a)*W +: W]);
      s    = in_tdata[9*W + a*(W-1) +: (W-1)];
      d    = (W+1)'(e) - (W+1)'(o);
      absd = d[W] ? (W+1)'(-d) : (W+1)'(d);
      o2   = NW'(o) <<< 1;
      lo2  = (NW'(c) <<< 1) - $signed(NW'({1'b0, s}));
      hi2  = (NW'(c) <<< 1) + $signed(NW'({1'b0, s}));
      nlo  = lo2 - o2;
      nhi  = hi2 - o2;
      s1_nlo_nxt[a]   = d[W] ? -nlo : nlo;
      s1_nhi_nxt[a]   = d[W] ? -nhi : nhi;
      s1_den_nxt[a]   = {absd, 1'b0};
      s1_dz_nxt[a]    = (d == '0);
      s1_zmiss_nxt[a] = (o2 < lo2) || (o2 > hi2);
    end
  end

  // stage 2: ordered, clamped crossings per axis
  logic          s2_v_r;
  logic [FW-1:0] s2_en_r [3];
  logic [FW-1:0] s2_ex_r [3];
  logic [FW-1:0] s2_den_r [3];
  logic          s2_miss_r;

  logic [FW-1:0] s2_en_nxt [3];
  logic [FW-1:0] s2_ex_nxt [3];
  logic [FW-1:0] s2_den_nxt [3];
  logic          s2_miss_nxt;

  always_comb begin
    s2_miss_nxt = 1'b0;
    for (int a = 0; a < 3; a++) begin
      logic signed [NW-1:0] en;
      logic signed [NW-1:0] ex;
      logic signed [NW-1:0] dn;
      en = (s1_nlo_r[a] < s1_nhi_r[a]) ? s1_nlo_r[a] : s1_nhi_r[a];
      ex = (s1_nlo_r[a] < s1_nhi_r[a]) ? s1_nhi_r[a] : s1_nlo_r[a];
      dn = $signed(NW'({1'b0, s1_den_r[a]}));
      if (s1_dz_r[a]) begin
        s2_en_nxt[a]  = '0;
        s2_ex_nxt[a]  = FW'(1);
        s2_den_nxt[a] = FW'(1);
        s2_miss_nxt   = s2_miss_nxt | s1_zmiss_r[a];
      end else begin
        s2_en_nxt[a]  = (en < 0) ? '0 : en[FW-1:0];
        s2_ex_nxt[a]  = (ex > dn) ? s1_den_r[a] : ex[FW-1:0];
        s2_den_nxt[a] = s1_den_r[a];
        s2_miss_nxt   = s2_miss_nxt | (ex < 0) | (en > dn);
      end
    end
  end

  // stage 3: combine x and y
  logic          s3_v_r;
  logic [FW-1:0] s3_mn_r, s3_md_r, s3_xn_r, s3_xd_r;
  logic [FW-1:0] s3_zen_r, s3_zex_r, s3_zden_r;
  logic          s3_miss_r;
  logic          s3_ygt, s3_xgt;

  assign s3_ygt = frac_gt(s2_en_r[1], s2_den_r[1], s2_en_r[0], s2_den_r[0]);
  assign s3_xgt = frac_gt(s2_ex_r[0], s2_den_r[0], s2_ex_r[1], s2_den_r[1]);

  // stage 4: combine with z
  logic          s4_v_r;
  logic [FW-1:0] s4_mn_r, s4_md_r, s4_xn_r, s4_xd_r;
  logic          s4_miss_r;
  logic          s4_zgt, s4_tgt;

  assign s4_zgt = frac_gt(s3_zen_r, s3_zden_r, s3_mn_r, s3_md_r);
  assign s4_tgt = frac_gt(s3_xn_r, s3_xd_r, s3_zex_r, s3_zden_r);

  // stage 5: empty interval check; feeds the divider
  logic          hit_nxt;
  assign hit_nxt = !s4_miss_r && !frac_gt(s4_mn_r, s4_md_r, s4_xn_r, s4_xd_r);

  logic          dv_r   [DS+1];
  logic [NW-1:0] drem_r [DS+1];
  logic [FW-1:0] dden_r [DS+1];
  logic [F:0]    dq_r   [DS+1];
  logic          dhit_r [DS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      dv_r[0] <= 1'b0;
    end else if (ce) begin
      s1_v_r  <= in_tvalid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      dv_r[0] <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_nlo_r   <= s1_nlo_nxt;
      s1_nhi_r   <= s1_nhi_nxt;
      s1_den_r   <= s1_den_nxt;
      s1_dz_r    <= s1_dz_nxt;
      s1_zmiss_r <= s1_zmiss_nxt;

      s2_en_r   <= s2_en_nxt;
      s2_ex_r   <= s2_ex_nxt;
      s2_den_r  <= s2_den_nxt;
      s2_miss_r <= s2_miss_nxt;

      s3_mn_r   <= s3_ygt ? s2_en_r[1]  : s2_en_r[0];
      s3_md_r   <= s3_ygt ? s2_den_r[1] : s2_den_r[0];
      s3_xn_r   <= s3_xgt ? s2_ex_r[1]  : s2_ex_r[0];
      s3_xd_r   <= s3_xgt ? s2_den_r[1] : s2_den_r[0];
      s3_zen_r  <= s2_en_r[2];
      s3_zex_r  <= s2_ex_r[2];
      s3_zden_r <= s2_den_r[2];
      s3_miss_r <= s2_miss_r;

      s4_mn_r   <= s4_zgt ? s3_zen_r  : s3_mn_r;
      s4_md_r   <= s4_zgt ? s3_zden_r : s3_md_r;
      s4_xn_r   <= s4_tgt ? s3_zex_r  : s3_xn_r;
      s4_xd_r   <= s4_tgt ? s3_zden_r : s3_xd_r;
      s4_miss_r <= s3_miss_r;

      drem_r[0] <= NW'(s4_mn_r);
      dden_r[0] <= s4_md_r;
      dq_r[0]   <= '0;
      dhit_r[0] <= hit_nxt;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [NW-1:0] t;
    logic          qb;
    assign t  = (k == 0) ? drem_r[k] : (drem_r[k] << 1);
    assign qb = (t >= NW'(dden_r[k]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (ce) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        drem_r[k+1] <= qb ? (t - NW'(dden_r[k])) : t;
        dden_r[k+1] <= dden_r[k];
        dq_r[k+1]   <= {dq_r[k][F-1:0], qb};
        dhit_r[k+1] <= dhit_r[k];
      end
    end
  end

  assign out_tvalid = dv_r[DS];
  assign out_tdata  = OUT_W'({(dhit_r[DS] ? dq_r[DS] : {(F+1){1'b0}}), dhit_r[DS]});

endmodule

// ===== hdl/rsbst_checker.sv =====
// ----------------------------------------------------------------------------
// rsbst_checker
// port-level checks for the slab test pipeline
// ----------------------------------------------------------------------------
module rsbst_checker #(
  parameter int unsigned COORD_WIDTH = rsbst_pkg::COORD_WIDTH_DEF,
  parameter int unsigned T_FRAC_BITS = rsbst_pkg::T_FRAC_BITS_DEF,
  localparam int unsigned IN_BITS  = 9 * COORD_WIDTH + 3 * (COORD_WIDTH - 1),
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W    = ((T_FRAC_BITS + 2 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam logic [T_FRAC_BITS:0] ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

  logic [T_FRAC_BITS:0] entry;
  assign entry = out_tdata[T_FRAC_BITS+1:1];

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> entry == '0)
    else $error("miss with nonzero entry parameter");

  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> entry <= ONE)
    else $error("entry parameter above one");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input stalled while output free");

endmodule

bind ray_segment_box_slab_test rsbst_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .T_FRAC_BITS(T_FRAC_BITS)
) u_rsbst_checker (.*);
